[design/glyph_atlas_cache_assert.svh]
// ----------------------------------------------------------------------------
// glyph atlas cache assertion macros
// wrappers for concurrent checks, clocked on clk_i; GAC_ASSERT is quiet while in reset, GAC_ASSERT_ALWAYS is not
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_CACHE_ASSERT_SVH
`define GLYPH_ATLAS_CACHE_ASSERT_SVH

`ifndef ASSERT_OFF
`define GAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GAC_ASSERT(lbl, prop, msg)
`define GAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/gac_pkg.sv]
// ----------------------------------------------------------------------------
// gac_pkg
// shared types and constants of the glyph atlas cache
// ----------------------------------------------------------------------------
package gac_pkg;

  localparam int KEY_W       = 48;
  localparam int KEY_BYTES   = 6;
  localparam int DATA_W      = 72;   // placement (36) and metrics (36)
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;
  localparam int LIMIT_W     = 13;
  localparam int GLYPH_W     = 9;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 13'd3072;

  // configuration register indexes
  localparam logic REG_PADDING    = 1'b0;
  localparam logic REG_LOAD_LIMIT = 1'b1;

  typedef struct packed {
    logic                  too_large;
    logic                  flushed;
    logic                  hit;
    logic [DATA_W-1:0]     data;
  } res_t;

endpackage

[design/gac_ram.sv]
// ----------------------------------------------------------------------------
// gac_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/glyph_atlas_cache.sv]
// ----------------------------------------------------------------------------
// glyph_atlas_cache
// glyph lookup with sdbm hash, linear probing and shelf packing in an atlas
// ----------------------------------------------------------------------------
// One request at a time. A request is accepted, hashed one key byte per
// cycle and probed slot by slot (key ram read, then compare); a miss that
// fits is then placed and written. Then the result is handed over. Every
// cache clear sweeps all TABLE_SLOTS slots of the key ram, one slot a cycle;
// the same clearing pass runs after reset before the first item is taken.
// The output register lets the next item in while a result waits.
`include "glyph_atlas_cache_assert.svh"

module glyph_atlas_cache
  import gac_pkg::*;
#(
  parameter int TABLE_SLOTS = 4096,
  parameter int ATLAS_SIZE  = 512
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // font_id, size_code, glyph_id, sub_x, sub_y, glyph_width, glyph_height,
  // bearing_x, bearing_y, advance_in, zero fill
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // atlas_s, atlas_t, width_out, height_out, offset_x, offset_y, advance_out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // hit, flushed, too_large
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_addr_i,
  input  logic [LIMIT_W-1:0]     cfg_data_i
);

  localparam int IW    = $clog2(TABLE_SLOTS);
  localparam int CW    = IW + 1;
  localparam int CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int AW    = $clog2(ATLAS_SIZE);
  localparam int SW    = (AW + 2 > 11) ? AW + 2 : 11;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_RD, S_CK, S_DEC, S_SIZE, S_FIT, S_WR, S_CLR, S_OUT
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic                     pad_q, pad_d;
  logic [LIMIT_W-1:0]       limit_q, limit_d;
  logic [KEY_BYTES-1:0][7:0] key_q, key_d;
  logic [GLYPH_W-1:0]       w_q, w_d, h_q, h_d;
  logic [9:0]               bx_q, bx_d, by_q, by_d;
  logic [15:0]              adv_q, adv_d;
  logic [2:0]               bi_q, bi_d;
  logic [IW-1:0]            hash_q, hash_d, pos_q, pos_d, clr_q, clr_d;
  logic [CW-1:0]            n_q, n_d, cnt_q, cnt_d;
  logic [SW-1:0]            sx_q, sx_d, sy_q, sy_d, sh_q, sh_d;
  res_t                     res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  res_t                     out_q, out_d;

  logic                     kwe, dwe;
  logic [IW-1:0]            kwaddr;
  logic [KEY_W:0]           kwdata, krdata;
  logic [DATA_W-1:0]        ddata, drdata;
  logic [IW-1:0]            hstep;
  logic [SW-1:0]            padx, wx, hx, atl;

  assign padx = SW'(pad_q);
  assign wx   = SW'(w_q);
  assign hx   = SW'(h_q);
  assign atl  = SW'(ATLAS_SIZE);
  assign ddata = {adv_q, by_q, bx_q, h_q, w_q, sy_q[8:0], sx_q[8:0]};

  assign hstep = IW'(key_q[bi_q]) + (hash_q << 6) + (hash_q << 16) - hash_q;

  gac_ram #(.Width(KEY_W + 1), .Depth(TABLE_SLOTS)) u_key_ram (
    .clk_i,
    .we_i    (kwe),
    .waddr_i (kwaddr),
    .wdata_i (kwdata),
    .raddr_i (pos_q),
    .rdata_o (krdata)
  );

  gac_ram #(.Width(DATA_W), .Depth(TABLE_SLOTS)) u_data_ram (
    .clk_i,
    .we_i    (dwe),
    .waddr_i (pos_q),
    .wdata_i (ddata),
    .raddr_i (pos_q),
    .rdata_o (drdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tuser_o  = {out_q.too_large, out_q.flushed, out_q.hit};

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pad_d   = pad_q;
    limit_d = limit_q;
    key_d   = key_q;
    w_d     = w_q;
    h_d     = h_q;
    bx_d    = bx_q;
    by_d    = by_q;
    adv_d   = adv_q;
    bi_d    = bi_q;
    hash_d  = hash_q;
    pos_d   = pos_q;
    clr_d   = clr_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sh_d    = sh_q;
    res_d   = res_q;
    out_valid_d = out_valid_q;
    out_d   = out_q;
    kwe     = 1'b0;
    dwe     = 1'b0;
    kwaddr  = pos_q;
    kwdata  = {1'b1, key_q};

    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_PADDING:    pad_d   = cfg_data_i[0];
        REG_LOAD_LIMIT: limit_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        clr_d   = '0;
        ret_d   = S_IDLE;
        state_d = S_CLR;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          key_d  = s_axis_tdata_i[47:0];
          w_d    = s_axis_tdata_i[56:48];
          h_d    = s_axis_tdata_i[65:57];
          bx_d   = s_axis_tdata_i[75:66];
          by_d   = s_axis_tdata_i[85:76];
          adv_d  = s_axis_tdata_i[101:86];
          bi_d   = '0;
          hash_d = '0;
          res_d  = '0;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        hash_d = hstep;
        bi_d   = bi_q + 3'd1;
        if (bi_q == 3'(KEY_BYTES - 1)) begin
          pos_d   = hstep;
          n_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CK;
      end
      S_CK: begin
        if (!krdata[KEY_W]) begin
          state_d = S_DEC;
        end else if (krdata[KEY_W-1:0] == key_q) begin
          res_d.hit  = 1'b1;
          res_d.data = drdata;
          state_d    = S_OUT;
        end else begin
          pos_d = pos_q + IW'(1);
          n_d   = n_q + CW'(1);
          // every slot taken: count has reached the slot total, clear follows
          state_d = (n_q == CW'(TABLE_SLOTS - 1)) ? S_DEC : S_RD;
        end
      end
      S_DEC: begin
        if (CMPW'(cnt_q) >= CMPW'(limit_q) || cnt_q >= CW'(TABLE_SLOTS)) begin
          res_d.flushed = 1'b1;
          cnt_d   = '0;
          sx_d    = padx;
          sy_d    = padx;
          sh_d    = '0;
          pos_d   = hash_q;
          clr_d   = '0;
          ret_d   = S_SIZE;
          state_d = S_CLR;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        if (hx + padx > atl || wx + padx > atl) begin
          res_d.too_large = 1'b1;
          res_d.data      = '0;
          state_d         = S_OUT;
        end else begin
          if (sx_q + wx + padx > atl) begin
            sy_d = sy_q + sh_q + padx;
            sx_d = padx;
            sh_d = '0;
          end
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        // atlas full: start over at the corner
        if (sy_q + hx + padx > atl) begin
          res_d.flushed = 1'b1;
          cnt_d   = '0;
          sx_d    = padx;
          sy_d    = padx;
          sh_d    = '0;
          pos_d   = hash_q;
          clr_d   = '0;
          ret_d   = S_WR;
          state_d = S_CLR;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        kwe   = 1'b1;
        dwe   = 1'b1;
        cnt_d = cnt_q + CW'(1);
        res_d.data = ddata;
        sx_d  = sx_q + wx + padx;
        if (sh_q < hx + padx) begin
          sh_d = hx + padx;
        end
        state_d = S_OUT;
      end
      S_CLR: begin
        kwe    = 1'b1;
        kwaddr = clr_q;
        kwdata = '0;
        clr_d  = clr_q + IW'(1);
        if (clr_q == IW'(TABLE_SLOTS - 1)) begin
          state_d = ret_q;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_IDLE;
      pad_q       <= 1'b1;
      limit_q     <= LOAD_LIMIT_RST;
      cnt_q       <= '0;
      sx_q        <= SW'(1);
      sy_q        <= SW'(1);
      sh_q        <= '0;
      clr_q       <= '0;
      bi_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pad_q       <= pad_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sh_q        <= sh_d;
      clr_q       <= clr_d;
      bi_q        <= bi_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_d_reg: begin
      key_q  <= key_d;
      w_q    <= w_d;
      h_q    <= h_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      adv_q  <= adv_d;
      hash_q <= hash_d;
      pos_q  <= pos_d;
      res_q  <= res_d;
      out_q  <= out_d;
    end
  end

  `GAC_ASSERT(a_count_bound, cnt_q <= CW'(TABLE_SLOTS), "entry count above slot total")
  `GAC_ASSERT(a_fit_x, (state_q == S_WR) |-> (sx_q + wx <= atl),
              "placement runs past the atlas edge")
  `GAC_ASSERT(a_fit_y, (state_q == S_WR) |-> (sy_q + hx <= atl),
              "placement runs past the atlas bottom")
  `GAC_ASSERT(a_probe_bound, (state_q == S_CK) |-> (n_q < CW'(TABLE_SLOTS)),
              "probe ran past every slot")
  `GAC_ASSERT(a_no_write_in_probe, (state_q == S_RD || state_q == S_CK) |-> !kwe,
              "key ram written while a probe read is pending")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph atlas cache testbench
// sends glyph requests over the input stream and checks every returned
// placement against a local cache and shelf-packing predictor
// ----------------------------------------------------------------------------

class glyph_scoreboard;
  bit          slot_valid[4096];
  logic [47:0] slot_key[4096];
  logic [35:0] slot_place[4096];
  logic [35:0] slot_metrics[4096];
  int unsigned entries, shelf_x, shelf_y, shelf_h, padding, load_limit;
  gac_pkg::res_t pending[$];
  int errors;

  function void reset_state();
    padding = 1;
    load_limit = 3072;
    errors = 0;
    clear_cache();
  endfunction

  function void clear_cache();
    foreach (slot_valid[i]) slot_valid[i] = 0;
    entries = 0;
    shelf_x = padding;
    shelf_y = padding;
    shelf_h = 0;
  endfunction

  function void write_reg(logic addr, logic [12:0] data);
    if (addr == gac_pkg::REG_PADDING) padding = 32'(data[0]);
    else load_limit = 32'(data);
  endfunction

  function int unsigned key_hash(logic [47:0] key);
    int unsigned h;
    h = 0;
    for (int i = 0; i < 6; i++) h = key[8*i +: 8] + (h << 6) + (h << 16) - h;
    return h;
  endfunction

  // returns a matching slot or the first empty one, or -1 when every slot is taken
  function int find_slot(logic [47:0] key, output bit match);
    int unsigned pos;
    pos = key_hash(key) & 4095;
    match = 0;
    for (int n = 0; n < 4096; n++) begin
      if (!slot_valid[pos]) return pos;
      if (slot_key[pos] == key) begin
        match = 1;
        return pos;
      end
      pos = (pos + 1) & 4095;
    end
    return -1;
  endfunction

  function void note_request(logic [103:0] td);
    logic [47:0]   key;
    int unsigned   w, h;
    logic [35:0]   met;
    bit            match;
    int            pos;
    gac_pkg::res_t r;
    key = td[47:0];
    w = 32'(td[56:48]);
    h = 32'(td[65:57]);
    met = td[101:66];
    r = '0;
    pos = find_slot(key, match);
    if (pos >= 0 && match) begin
      r.hit = 1;
      r.data = {slot_metrics[pos], slot_place[pos]};
      pending.push_back(r);
      return;
    end
    if (entries >= load_limit || entries >= 4096) begin
      clear_cache();
      r.flushed = 1;
    end
    if (h + padding > 512 || w + padding > 512) begin
      r.too_large = 1;
      pending.push_back(r);
      return;
    end
    if (shelf_x + w + padding > 512) begin
      shelf_y += shelf_h + padding;
      shelf_x = padding;
      shelf_h = 0;
    end
    if (shelf_y + h + padding > 512) begin
      clear_cache();
      r.flushed = 1;
    end
    pos = find_slot(key, match);
    slot_valid[pos] = 1;
    slot_key[pos] = key;
    slot_place[pos] = {h[8:0], w[8:0], shelf_y[8:0], shelf_x[8:0]};
    slot_metrics[pos] = met;
    entries++;
    r.data = {met, slot_place[pos]};
    pending.push_back(r);
    shelf_x += w + padding;
    if (shelf_h < h + padding) shelf_h = h + padding;
  endfunction

  function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(logic [71:0] td, logic [2:0] tu);
    gac_pkg::res_t e;
    if (pending.size() == 0) begin
      $error("result item with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    cmp("hit", 16'(e.hit), 16'(tu[0]));
    cmp("flushed", 16'(e.flushed), 16'(tu[1]));
    cmp("too_large", 16'(e.too_large), 16'(tu[2]));
    cmp("atlas_s", 16'(e.data[8:0]), 16'(td[8:0]));
    cmp("atlas_t", 16'(e.data[17:9]), 16'(td[17:9]));
    cmp("width_out", 16'(e.data[26:18]), 16'(td[26:18]));
    cmp("height_out", 16'(e.data[35:27]), 16'(td[35:27]));
    cmp("offset_x", 16'(e.data[45:36]), 16'(td[45:36]));
    cmp("offset_y", 16'(e.data[55:46]), 16'(td[55:46]));
    cmp("advance_out", e.data[71:56], td[71:56]);
  endfunction
endclass

module testbench;
  import gac_pkg::*;

  logic                   clk_i = 0;
  logic                   rst_ni = 0;
  logic                   s_axis_tvalid_i = 0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   cfg_valid_i = 0;
  logic                   cfg_ready_o;
  logic                   cfg_addr_i = 0;
  logic [LIMIT_W-1:0]     cfg_data_i = '0;

  glyph_scoreboard glyphs = new();
  bit          no_idle = 0;
  int          stuck_cycles = 0;
  logic [47:0] recent_keys[$];

  glyph_atlas_cache DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // result side stalls at random, except while no_idle is set
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= 38);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      glyphs.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= 40000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_glyph(logic [47:0] key, logic [8:0] w, logic [8:0] h,
                            logic [9:0] bx, logic [9:0] by, logic [15:0] adv);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 38) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {2'b00, adv, by, bx, h, w, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    glyphs.note_request(s_axis_tdata_i);
    if (recent_keys.size() < 64) recent_keys.push_back(key);
    else recent_keys[$urandom_range(0, 63)] = key;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (glyphs.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic addr, logic [LIMIT_W-1:0] data);
    cfg_valid_i <= 1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    glyphs.write_reg(addr, data);
    @(posedge clk_i);
  endtask

  task automatic random_glyphs(int count, int calm_from, int calm_to);
    logic [47:0] key;
    logic [8:0]  w, h;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= calm_from && i < calm_to);
      if (recent_keys.size() > 0 && $urandom_range(0, 99) < 40)
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
        key = 48'({$urandom(), $urandom()});
      // mostly small glyphs so the atlas holds many, a few huge ones
      if ($urandom_range(0, 99) < 4) begin
        w = 9'($urandom());
        h = 9'($urandom());
      end else begin
        w = 9'($urandom_range(0, 48));
        h = 9'($urandom_range(0, 48));
      end
      send_glyph(key, w, h, 10'($urandom()), 10'($urandom()), 16'($urandom()));
    end
    no_idle = 0;
  endtask

  initial begin
    glyphs.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // directed: key extremes, hits, largest glyphs, row full, atlas full
    send_glyph('0, 9'd0, 9'd0, 10'h200, 10'h1ff, 16'h0000);
    send_glyph('1, 9'd510, 9'd1, 10'h1ff, 10'h200, 16'hffff);
    send_glyph('0, 9'd5, 9'd5, 10'h000, 10'h000, 16'h1234);
    send_glyph('1, 9'd1, 9'd1, 10'h3ff, 10'h3ff, 16'h0001);
    send_glyph(48'h1, 9'd511, 9'd0, 10'h0, 10'h0, 16'h0);
    send_glyph(48'h2, 9'd0, 9'd511, 10'h0, 10'h0, 16'h0);
    send_glyph(48'h2, 9'd3, 9'd4, 10'h1, 10'h2, 16'h3);
    send_glyph(48'hc000_0000_0000, 9'd200, 9'd100, 10'h55, 10'h2aa, 16'h5555);
    send_glyph(48'h3000_0000_0000, 9'd200, 9'd120, 10'h2aa, 10'h155, 16'haaaa);
    send_glyph(48'h0fff_f000_0000, 9'd200, 9'd30, 10'h12, 10'h34, 16'h5678);
    send_glyph(48'h0000_0fff_ff00, 9'd100, 9'd300, 10'h3, 10'h4, 16'h9);
    send_glyph(48'h0000_0000_00ff, 9'd100, 9'd300, 10'h5, 10'h6, 16'h7);
    send_glyph(48'h0fff_f000_0000, 9'd9, 9'd9, 10'h0, 10'h0, 16'h0);
    send_glyph('0, 9'd7, 9'd7, 10'h0, 10'h0, 16'h0);
    send_glyph(48'h0000_0000_00ff, 9'd1, 9'd1, 10'h0, 10'h0, 16'h0);
    send_glyph(48'h2, 9'd511, 9'd511, 10'h0, 10'h0, 16'h0);
    drain();

    write_cfg(REG_PADDING, 13'd0);
    write_cfg(REG_LOAD_LIMIT, 13'd4096);
    send_glyph(48'h7, 9'd511, 9'd511, 10'h0, 10'h0, 16'h0);
    send_glyph(48'h8, 9'd511, 9'd3, 10'h0, 10'h0, 16'h0);
    random_glyphs(550, -1, -1);
    drain();

    write_cfg(REG_PADDING, 13'd1);
    write_cfg(REG_LOAD_LIMIT, 13'd4095);
    random_glyphs(550, 100, 350);
    drain();

    // every miss clears the cache
    write_cfg(REG_PADDING, 13'd0);
    write_cfg(REG_LOAD_LIMIT, 13'd1);
    random_glyphs(20, -1, -1);
    drain();

    write_cfg(REG_PADDING, 13'd1);
    write_cfg(REG_LOAD_LIMIT, 13'd3);
    random_glyphs(30, -1, -1);
    drain();

    if (glyphs.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
